[hdl/sidv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed divider package
// Shared defaults and the control word that travels down the divide pipeline.
// ----------------------------------------------------------------------------
package sidv_pkg;

    // Default operand width
    localparam int DATA_WIDTH_DEFAULT = 32;

    // Per-stage control: request valid, sign fix-up and the two special cases
    typedef struct packed {
        logic valid;
        logic neg;
        logic sat;
        logic dbz;
    } ctl_t;

endpackage : sidv_pkg
`default_nettype wire

[hdl/sidv_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed divider restoring stage
// Settles one quotient bit: shift in the next dividend bit, trial subtract.
// ----------------------------------------------------------------------------
module sidv_stage #(
    parameter int DATA_WIDTH = sidv_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  sidv_pkg::ctl_t        ctl_in,
    input  logic [DATA_WIDTH-1:0] rem_in,
    input  logic [DATA_WIDTH-1:0] num_in,
    input  logic [DATA_WIDTH-1:0] den_in,
    input  logic [DATA_WIDTH-1:0] quo_in,
    output sidv_pkg::ctl_t        ctl_out,
    output logic [DATA_WIDTH-1:0] rem_out,
    output logic [DATA_WIDTH-1:0] num_out,
    output logic [DATA_WIDTH-1:0] den_out,
    output logic [DATA_WIDTH-1:0] quo_out
);
    import sidv_pkg::*;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;
    ctl_t                  ctl_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] num_reg;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] quo_next;

    always_comb
    begin
        shifted  = {rem_in, num_in[DATA_WIDTH-1]};
        diff     = shifted - {1'b0, den_in};
        fits     = (shifted >= {1'b0, den_in});
        // remainder stays below the divisor, so it fits the operand width
        rem_next = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        quo_next = {quo_in[DATA_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_in[DATA_WIDTH-2:0], 1'b0};
            den_reg <= den_in;
            quo_reg <= quo_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;

endmodule : sidv_stage
`default_nettype wire

[hdl/signed_integer_divider_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed integer divider unit
// Pipelined signed division, quotient truncated toward zero, with flags.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: dividend in the low DATA_WIDTH bits
//   of s_axis_tdata, divisor directly above it. Results leave on m_axis:
//   quotient in m_axis_tdata, saturated in m_axis_tuser[0] and divide_by_zero
//   in m_axis_tuser[1]. Each request gives exactly one result, in order.
//   m_axis_tvalid rises once a request has passed the whole pipeline: the
//   magnitude register loads on the accepting edge, then one restoring stage
//   per quotient bit and the sign fix-up and output register follow. The chain
//   of DATA_WIDTH bit stages is fully pipelined, so a new request is taken
//   every cycle while the output moves.
//   A zero divisor gives quotient 0 with divide_by_zero set; the most
//   negative dividend over minus one gives the largest positive value with
//   saturated set.
//   When the receiver holds m_axis_tready low with a result waiting, the
//   whole pipeline holds and s_axis_tready drops; nothing is lost or repeated.
//   Reset clears every valid bit, so the pipeline comes up empty.
// ----------------------------------------------------------------------------
module signed_integer_divider_unit #(
    parameter int DATA_WIDTH = sidv_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: dividend, divisor, zero fill
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: quotient, zero fill
    output logic [((DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    // tuser: saturated, divide_by_zero
    output logic [1:0]                          m_axis_tuser
);
    import sidv_pkg::*;

    localparam int OUT_BITS = ((DATA_WIDTH + 7) / 8) * 8;
    localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MINUS_ONE = {DATA_WIDTH{1'b1}};

    // Global advance: the pipeline moves when the output slot is free or taken
    logic advance;

    // Inter-stage buses; index 0 is the magnitude stage output
    ctl_t                  ctl_s [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem_s [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] num_s [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] den_s [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] quo_s [0:DATA_WIDTH];

    // Input decode
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;
    logic                  a_neg;
    logic                  b_neg;
    ctl_t                  ctl_in_next;
    logic [DATA_WIDTH-1:0] a_mag_next;
    logic [DATA_WIDTH-1:0] b_mag_next;

    ctl_t                  ctl_in_reg;
    logic [DATA_WIDTH-1:0] a_mag_reg;
    logic [DATA_WIDTH-1:0] b_mag_reg;

    // Output register
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] quotient_reg;
    logic [DATA_WIDTH-1:0] quotient_next;
    logic                  saturated_reg;
    logic                  dbz_reg;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    // Magnitude stage: take absolute values and flag the special cases
    always_comb
    begin
        dividend          = s_axis_tdata[DATA_WIDTH-1:0];
        divisor           = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
        a_neg             = dividend[DATA_WIDTH-1];
        b_neg             = divisor[DATA_WIDTH-1];
        a_mag_next        = a_neg ? (~dividend + 1'b1) : dividend;
        b_mag_next        = b_neg ? (~divisor + 1'b1) : divisor;
        ctl_in_next.valid = s_axis_tvalid;
        ctl_in_next.neg   = a_neg ^ b_neg;
        ctl_in_next.dbz   = (divisor == '0);
        ctl_in_next.sat   = (dividend == MOST_NEG) && (divisor == MINUS_ONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_in_reg <= '0;
        end
        else if (advance)
        begin
            ctl_in_reg <= ctl_in_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_mag_reg <= a_mag_next;
            b_mag_reg <= b_mag_next;
        end
    end

    assign ctl_s[0] = ctl_in_reg;
    assign rem_s[0] = '0;
    assign num_s[0] = a_mag_reg;
    assign den_s[0] = b_mag_reg;
    assign quo_s[0] = '0;

    // One restoring stage per quotient bit, most significant bit first
    genvar g;
    generate
        for (g = 0; g < DATA_WIDTH; g++)
        begin : g_stage
            sidv_stage #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_stage (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .ctl_in  (ctl_s[g]),
                .rem_in  (rem_s[g]),
                .num_in  (num_s[g]),
                .den_in  (den_s[g]),
                .quo_in  (quo_s[g]),
                .ctl_out (ctl_s[g+1]),
                .rem_out (rem_s[g+1]),
                .num_out (num_s[g+1]),
                .den_out (den_s[g+1]),
                .quo_out (quo_s[g+1])
            );
        end
    endgenerate

    // Sign fix-up; a zero divisor wins over saturation
    always_comb
    begin
        if (ctl_s[DATA_WIDTH].dbz)
        begin
            quotient_next = '0;
        end
        else if (ctl_s[DATA_WIDTH].sat)
        begin
            quotient_next = MOST_POS;
        end
        else if (ctl_s[DATA_WIDTH].neg)
        begin
            quotient_next = ~quo_s[DATA_WIDTH] + 1'b1;
        end
        else
        begin
            quotient_next = quo_s[DATA_WIDTH];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= ctl_s[DATA_WIDTH].valid;
        end
    end

    // Hold the result while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            quotient_reg  <= quotient_next;
            saturated_reg <= ctl_s[DATA_WIDTH].sat && !ctl_s[DATA_WIDTH].dbz;
            dbz_reg       <= ctl_s[DATA_WIDTH].dbz;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_BITS'(quotient_reg);
    assign m_axis_tuser  = {dbz_reg, saturated_reg};

endmodule : signed_integer_divider_unit
`default_nettype wire

[bench/signed_integer_divider_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer divider unit testbench
// Drives division requests through the stream input with random gaps. Drains
// results under random back-pressure. Checks every quotient and both flags
// against a bench predictor or a typed-in answer. A short table of corner
// requests comes first, then a long run of random operands.
// ----------------------------------------------------------------------------
module signed_integer_divider_unit_tb;

    localparam int W           = sidv_pkg::DATA_WIDTH_DEFAULT;
    localparam int S_BITS      = ((2*W+7)/8)*8;
    localparam int M_BITS      = ((W+7)/8)*8;
    localparam int LATENCY     = W + 2;
    localparam int RANDOM_REQS = 1250;
    localparam int REPORT_MAX  = 10;

    // Operand values with a meaning of their own
    localparam logic [W-1:0] ZERO      = '0;
    localparam logic [W-1:0] ONE       = {{(W-1){1'b0}}, 1'b1};
    localparam logic [W-1:0] MINUS_ONE = '1;
    localparam logic [W-1:0] MOST_NEG  = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MOST_POS  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] TWO       = ONE << 1;
    localparam logic [W-1:0] SEVEN     = 7;

    // What one request should come back as
    typedef struct packed {
        logic [W-1:0] quotient;
        logic         saturated;
        logic         divide_by_zero;
    } quo_result_t;

    // One row of the corner table; the answer is typed in only where fixed
    typedef struct packed {
        logic [W-1:0] dividend;
        logic [W-1:0] divisor;
        logic         fixed_answer;
        logic [W-1:0] quotient;
        logic         saturated;
        logic         divide_by_zero;
    } corner_row_t;

    localparam int CORNER_ROWS = 24;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // tdata: dividend, divisor, zero fill
    logic [S_BITS-1:0] s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // tdata: quotient, zero fill
    logic [M_BITS-1:0] m_axis_tdata;
    // tuser: saturated, divide_by_zero
    logic [1:0]        m_axis_tuser;

    quo_result_t       pending_quotients [$];
    corner_row_t       corner_rows [CORNER_ROWS];
    int                mismatch_count = 0;
    bit                drain_done     = 1'b0;

    signed_integer_divider_unit #(
        .DATA_WIDTH (W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Quotient predictor: divide the magnitudes, then restore the sign.
    // A zero divisor wins over the overflow case.
    // ------------------------------------------------------------------------
    function automatic quo_result_t predict_quotient(input logic [W-1:0] dividend,
                                                     input logic [W-1:0] divisor);
        quo_result_t  res;
        logic [W-1:0] num_mag;
        logic [W-1:0] den_mag;
        logic [W-1:0] quo_mag;
        res = '0;
        if (divisor == ZERO)
        begin
            res.divide_by_zero = 1'b1;
        end
        else if (dividend == MOST_NEG && divisor == MINUS_ONE)
        begin
            res.quotient  = MOST_POS;
            res.saturated = 1'b1;
        end
        else
        begin
            // Negating the most negative value wraps to its own magnitude
            num_mag = dividend[W-1] ? ZERO - dividend : dividend;
            den_mag = divisor[W-1] ? ZERO - divisor : divisor;
            quo_mag = num_mag / den_mag;
            res.quotient = (dividend[W-1] ^ divisor[W-1]) ? ZERO - quo_mag : quo_mag;
        end
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int draw_idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Operands that sit on the edges of the signed range
    function automatic logic [W-1:0] pick_edge_operand();
        case ($urandom_range(0, 7))
            0:       return ZERO;
            1:       return ONE;
            2:       return MINUS_ONE;
            3:       return MOST_NEG;
            4:       return MOST_POS;
            5:       return TWO;
            6:       return ZERO - TWO;
            default: return MOST_NEG + ONE;
        endcase
    endfunction

    // Small magnitude with a random sign
    function automatic logic [W-1:0] pick_small_operand(input int max_mag);
        logic [W-1:0] mag;
        mag = $urandom_range(1, max_mag);
        return $urandom_range(0, 1) ? ZERO - mag : mag;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: hold the request until taken, record its expectation,
    // then idle for a while unless inside a quiet stretch.
    // ------------------------------------------------------------------------
    int tx_quiet_left = 0;

    task automatic send_request(input logic [W-1:0] dividend,
                                input logic [W-1:0] divisor,
                                input quo_result_t  expected);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_BITS-2*W){1'b0}}, divisor, dividend};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_quotients = {pending_quotients, expected};
        if (tx_quiet_left > 0)
        begin
            tx_quiet_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            tx_quiet_left = $urandom_range(20, 80);
            gap = 0;
        end
        else
        begin
            gap = draw_idle_cycles();
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Corner table: sign combinations, range extremes and both special cases
    initial
    begin
        corner_rows = '{
            // dividend           divisor    fixed quotient   sat   dbz
            '{ZERO,               ONE,       1'b1, ZERO,      1'b0, 1'b0},
            '{SEVEN,              ONE,       1'b0, ZERO,      1'b0, 1'b0},
            '{MOST_NEG,           ONE,       1'b1, MOST_NEG,  1'b0, 1'b0},
            '{MOST_POS,           ONE,       1'b1, MOST_POS,  1'b0, 1'b0},
            '{MOST_NEG,           MINUS_ONE, 1'b1, MOST_POS,  1'b1, 1'b0},
            '{MOST_POS,           MINUS_ONE, 1'b0, ZERO,      1'b0, 1'b0},
            '{SEVEN,              ZERO,      1'b1, ZERO,      1'b0, 1'b1},
            '{MOST_NEG,           ZERO,      1'b1, ZERO,      1'b0, 1'b1},
            '{MOST_POS,           ZERO,      1'b1, ZERO,      1'b0, 1'b1},
            '{ZERO,               ZERO,      1'b1, ZERO,      1'b0, 1'b1},
            '{MINUS_ONE,          ZERO,      1'b1, ZERO,      1'b0, 1'b1},
            '{SEVEN,              TWO,       1'b0, ZERO,      1'b0, 1'b0},
            '{ZERO - SEVEN,       TWO,       1'b0, ZERO,      1'b0, 1'b0},
            '{SEVEN,              ZERO - TWO, 1'b0, ZERO,     1'b0, 1'b0},
            '{ZERO - SEVEN,       ZERO - TWO, 1'b0, ZERO,     1'b0, 1'b0},
            '{MOST_NEG,           MOST_NEG,  1'b0, ZERO,      1'b0, 1'b0},
            '{MOST_NEG,           MOST_POS,  1'b0, ZERO,      1'b0, 1'b0},
            '{MOST_POS,           MOST_NEG,  1'b0, ZERO,      1'b0, 1'b0},
            '{ONE,                MOST_NEG,  1'b0, ZERO,      1'b0, 1'b0},
            '{ZERO,               MOST_NEG,  1'b0, ZERO,      1'b0, 1'b0},
            '{MOST_NEG,           TWO,       1'b0, ZERO,      1'b0, 1'b0},
            '{MOST_NEG,           ZERO - TWO, 1'b0, ZERO,     1'b0, 1'b0},
            '{MINUS_ONE,          MINUS_ONE, 1'b0, ZERO,      1'b0, 1'b0},
            '{MOST_POS,           MOST_POS,  1'b0, ZERO,      1'b0, 1'b0}
        };
    end

    // ------------------------------------------------------------------------
    // Stimulus: reset, corner table, then random operands; drain and judge.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [W-1:0] dividend;
        logic [W-1:0] divisor;
        quo_result_t  expected;
        int           roll;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < CORNER_ROWS; row++)
        begin
            if (corner_rows[row].fixed_answer)
                expected = '{corner_rows[row].quotient, corner_rows[row].saturated,
                             corner_rows[row].divide_by_zero};
            else
                expected = predict_quotient(corner_rows[row].dividend,
                                            corner_rows[row].divisor);
            send_request(corner_rows[row].dividend, corner_rows[row].divisor, expected);
        end

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            roll     = $urandom_range(0, 99);
            dividend = $urandom();
            divisor  = $urandom();
            if (roll < 40)
            begin
                // full range on both sides
            end
            else if (roll < 60)
            begin
                divisor = pick_small_operand(255);
            end
            else if (roll < 70)
            begin
                dividend = pick_small_operand(1000);
                divisor  = pick_small_operand(40);
            end
            else if (roll < 80)
            begin
                dividend = pick_edge_operand();
                divisor  = pick_edge_operand();
            end
            else if (roll < 86)
            begin
                divisor = ZERO;
            end
            else
            begin
                // spread the divisor size so every quotient length turns up
                divisor = divisor >> $urandom_range(0, W-1);
                if (divisor == ZERO)
                    divisor = ONE;
                if ($urandom_range(0, 1))
                    divisor = ZERO - divisor;
            end
            send_request(dividend, divisor, predict_quotient(dividend, divisor));
        end
        s_axis_tvalid <= 1'b0;

        while (pending_quotients.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        drain_done = 1'b1;

        if (pending_quotients.size() != 0)
            $display("%0d results never arrived", pending_quotients.size());
        if (mismatch_count == 0 && pending_quotients.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result sink: random back-pressure with the odd long stall and quiet
    // stretches where every result is taken at once.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        int quiet_left;
        hold_left  = 0;
        quiet_left = 0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (quiet_left > 0)
                    quiet_left--;
                else if ($urandom_range(0, 99) < 2)
                    quiet_left = $urandom_range(30, 120);
                else if ($urandom_range(0, 99) < 30)
                    hold_left = draw_idle_cycles();
            end
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each taken result with the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        quo_result_t expected;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_quotients.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: quotient %h sat %b dbz %b",
                             m_axis_tdata[W-1:0], m_axis_tuser[0], m_axis_tuser[1]);
            end
            else
            begin
                expected = pending_quotients.pop_front();
                if (m_axis_tdata !== M_BITS'(expected.quotient)
                        || m_axis_tuser[0] !== expected.saturated
                        || m_axis_tuser[1] !== expected.divide_by_zero)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("mismatch: quotient %h/%h sat %b/%b dbz %b/%b (exp/got)",
                                 expected.quotient, m_axis_tdata[W-1:0],
                                 expected.saturated, m_axis_tuser[0],
                                 expected.divide_by_zero, m_axis_tuser[1]);
                end
            end
        end
    end

    // Give up well beyond the slowest legal run
    initial
    begin
        #8000000;
        if (!drain_done)
        begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
